FILE: rtl/ubx_ack_pkg.sv
package ubx_ack_pkg;

  // frame geometry
  localparam int unsigned FrameLen   = 10;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned ElapsedW   = 17;
  localparam int unsigned TimeoutW   = 16;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [IdxW-1:0]     FrameLast   = IdxW'(FrameLen);
  localparam logic [ElapsedW-1:0] ElapsedMax  = {ElapsedW{1'b1}};
  localparam logic [TimeoutW-1:0] TimeoutRst  = 16'd3000;

  // fixed frame bytes: sync chars, ACK-ACK class/id, payload length
  localparam logic [7:0] Sync1    = 8'hB5;
  localparam logic [7:0] Sync2    = 8'h62;
  localparam logic [7:0] AckClass = 8'h05;
  localparam logic [7:0] AckId    = 8'h01;
  localparam logic [7:0] LenLo    = 8'h02;
  localparam logic [7:0] LenHi    = 8'h00;

  // fletcher partial sums over the four fixed body bytes
  localparam logic [7:0] CkAFixed = AckClass + AckId + LenLo + LenHi;
  localparam logic [7:0] CkBFixed = AckClass + (AckClass + AckId)
                                  + (AckClass + AckId + LenLo) + CkAFixed;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_WAIT    = 2'd1,
    ST_ACKED   = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLASS   = 2'd0,
    REG_ID      = 2'd1,
    REG_TIMEOUT = 2'd2
  } cfg_reg_e;

endpackage

FILE: rtl/ubx_ack_in_if.sv
interface ubx_ack_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

FILE: rtl/ubx_ack_out_if.sv
interface ubx_ack_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [ubx_ack_pkg::IdxW-1:0]   matched_count;

  modport source (output valid, output status, output matched_count, input ready);
  modport sink   (input valid, input status, input matched_count, output ready);
endinterface

FILE: rtl/ubx_ack_matcher.sv
// ubx_ack_matcher: watches a received byte stream for the UBX ACK-ACK frame
// that acknowledges one sent message (class and id from the config port).
// in_i carries one beat per event: start, received byte or millisecond tick.
// out_o returns exactly one beat per input beat: status and matched byte count.
// Config registers (class, id, timeout) are written through cfg_we_i with
// cfg_idx_i selecting the register; write them only while no beat is in flight.
// A beat accepted on in_i is registered at the input stage, and its result is then
// loaded into the output register, from which it shows on out_o; a stall on out_o
// can hold the beat in the input stage before that load.
// Throughput: one beat per cycle while out_o is not stalled, set by the
// combinational state update between the input register and the output register.
// When the receiver stalls, the output register holds its beat and the input
// stage takes one more beat; after that in_i.ready falls until out_o drains.
// Reset (rst_ni low) empties both stages, returns to idle with the match index
// and elapsed count cleared, and loads the default timeout of 3000 ticks.
module ubx_ack_matcher (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ubx_ack_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ubx_ack_pkg::CfgDataW-1:0]      cfg_wdata_i,
  ubx_ack_in_if.sink                            in_i,
  ubx_ack_out_if.source                         out_o
);

  // configuration registers
  logic [7:0]                          cls_q;
  logic [7:0]                          id_q;
  logic [ubx_ack_pkg::TimeoutW-1:0]    timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q     <= '0;
      id_q      <= '0;
      timeout_q <= ubx_ack_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ubx_ack_pkg::REG_CLASS:   cls_q     <= cfg_wdata_i[7:0];
        ubx_ack_pkg::REG_ID:      id_q      <= cfg_wdata_i[7:0];
        ubx_ack_pkg::REG_TIMEOUT: timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input stage
  logic       s1_valid_q;
  logic [1:0] s1_action_q;
  logic [7:0] s1_byte_q;
  logic       out_valid_q;
  logic       s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_action_q <= in_i.action;
      s1_byte_q   <= in_i.rx_byte;
    end
  end

  // matcher state
  ubx_ack_pkg::status_e                phase_q, phase_d;
  logic [ubx_ack_pkg::IdxW-1:0]        idx_q, idx_d;
  logic [ubx_ack_pkg::ElapsedW-1:0]    elapsed_q, elapsed_d, elapsed_inc;
  logic [15:0]                         cksum_q, cksum_d;
  logic [7:0]                          exp_byte;
  logic [7:0]                          ck_a_new;
  logic [7:0]                          ck_b_new;

  // checksum of the expected frame from the live class and id
  assign ck_a_new = ubx_ack_pkg::CkAFixed + cls_q + id_q;
  assign ck_b_new = ubx_ack_pkg::CkBFixed + (ubx_ack_pkg::CkAFixed + cls_q) + ck_a_new;

  // expected byte at the current match position
  always_comb begin
    unique case (idx_q)
      4'd0:    exp_byte = ubx_ack_pkg::Sync1;
      4'd1:    exp_byte = ubx_ack_pkg::Sync2;
      4'd2:    exp_byte = ubx_ack_pkg::AckClass;
      4'd3:    exp_byte = ubx_ack_pkg::AckId;
      4'd4:    exp_byte = ubx_ack_pkg::LenLo;
      4'd5:    exp_byte = ubx_ack_pkg::LenHi;
      4'd6:    exp_byte = cls_q;
      4'd7:    exp_byte = id_q;
      4'd8:    exp_byte = cksum_q[7:0];
      default: exp_byte = cksum_q[15:8];
    endcase
  end

  // saturating tick count
  assign elapsed_inc = (elapsed_q < ubx_ack_pkg::ElapsedMax) ?
                       elapsed_q + 1'b1 : elapsed_q;

  // next state for one beat
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    elapsed_d = elapsed_q;
    cksum_d   = cksum_q;
    unique case (s1_action_q)
      ubx_ack_pkg::ACT_START: begin
        phase_d   = ubx_ack_pkg::ST_WAIT;
        idx_d     = '0;
        elapsed_d = '0;
        cksum_d   = {ck_b_new, ck_a_new};
      end
      ubx_ack_pkg::ACT_BYTE: begin
        if (phase_q == ubx_ack_pkg::ST_WAIT) begin
          if (idx_q < ubx_ack_pkg::FrameLast && s1_byte_q == exp_byte) begin
            idx_d = idx_q + 1'b1;
            if (idx_d >= ubx_ack_pkg::FrameLast) phase_d = ubx_ack_pkg::ST_ACKED;
          end else begin
            idx_d = '0;
          end
        end
      end
      ubx_ack_pkg::ACT_TICK: begin
        if (phase_q == ubx_ack_pkg::ST_WAIT) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc > {1'b0, timeout_q}) phase_d = ubx_ack_pkg::ST_TIMEOUT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ubx_ack_pkg::ST_IDLE;
      idx_q     <= '0;
      elapsed_q <= '0;
      cksum_q   <= '0;
    end else if (s1_adv) begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      elapsed_q <= elapsed_d;
      cksum_q   <= cksum_d;
    end
  end

  // output register
  logic [1:0]                    out_status_q;
  logic [ubx_ack_pkg::IdxW-1:0]  out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q <= phase_d;
      out_count_q  <= idx_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.matched_count = out_count_q;

`ifndef SYNTHESIS
  // match index never runs past the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= ubx_ack_pkg::FrameLast)
    else $error("match index beyond frame length");

  // acknowledged only with the whole frame matched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ubx_ack_pkg::ST_ACKED) |-> (idx_q == ubx_ack_pkg::FrameLast))
    else $error("acknowledged without full frame");

  // idle only before the first start, with clear counters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ubx_ack_pkg::ST_IDLE) |-> (idx_q == '0 && elapsed_q == '0))
    else $error("idle state with live counters");

  // a beat in the input stage stays there while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |=> (s1_valid_q && out_valid_q))
    else $error("beat lost under output stall");
`endif

endmodule
